### hw/rtl/spfs_pkg.sv
// Shared types, codes and constants of the serial peripheral frame sequencer.
// No dependencies; every other file of the block imports this package.
package spfs_pkg;

	// Fixed field widths of the item and result ports.
	localparam int ADDR_FIELD_W = 6;
	localparam int DATA_FIELD_W = 16;
	localparam int CMD_W        = 3;
	localparam int CHAN_W       = 2;
	localparam int CS_W         = 3;
	localparam int CFG_IDX_W    = 1;

	// Defaults of the top-level parameters.
	localparam int ADDR_BITS_DEF = 6;
	localparam int WORD_BITS_DEF = 16;
	localparam int DAC_BITS_DEF  = 12;

	localparam int QUEUE_DEPTH = 2;
	localparam int POT_FRAME_BITS = 10;
	localparam int POT_CODE_BITS  = 8;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 1'd1;
	localparam logic [15:0] POLL_LIMIT_RST   = 16'd30000;
	localparam logic [15:0] SETTLE_TICKS_RST = 16'd20000;

	// Command codes; a start command also names the operation of its frame.
	localparam logic [CMD_W-1:0] CMD_STEP  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DAC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EWEN  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_POT   = 3'd5;

	// Microwire start bit and opcode.
	localparam logic [2:0] EE_HDR_EWEN  = 3'b100;
	localparam logic [2:0] EE_HDR_READ  = 3'b110;
	localparam logic [2:0] EE_HDR_WRITE = 3'b101;

	// Chip select codes.
	localparam logic [CS_W-1:0] CS_NONE     = 3'd0;
	localparam logic [CS_W-1:0] CS_DAC      = 3'd1;
	localparam logic [CS_W-1:0] CS_DAC_LOAD = 3'd2;
	localparam logic [CS_W-1:0] CS_EEPROM   = 3'd3;
	localparam logic [CS_W-1:0] CS_POT      = 3'd4;

	// Longest outgoing frame for a given configuration.
	function automatic int frame_width(input int addr_bits, input int word_bits,
		input int dac_bits);
		int ee_w;
		int dac_w;
		ee_w  = 3 + addr_bits + word_bits;
		dac_w = 4 + dac_bits;
		return (ee_w > dac_w) ? ee_w : dac_w;
	endfunction

	// Classified step as it travels from the front end to the sequencer.
	typedef struct packed {
		logic             start;
		logic [CMD_W-1:0] op;
		logic             sin;
	} step_ctl_t;

	typedef struct packed {
		logic [15:0] poll_limit;
		logic [15:0] settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [CS_W-1:0]         cs;
		logic                    sout;
		logic                    busy;
		logic                    done;
		logic [DATA_FIELD_W-1:0] read_data;
		logic                    tmo;
		logic                    rej;
	} res_t;

endpackage

### hw/rtl/spfs_front.sv
// Front end: classifies each incoming item and builds its outgoing frame.
// Depends on spfs_pkg.
module spfs_front import spfs_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int DAC_BITS  = DAC_BITS_DEF,
	localparam int SHIFT_W  = frame_width(ADDR_BITS, WORD_BITS, DAC_BITS),
	localparam int CNT_W    = $clog2(SHIFT_W + 1)
) (
	input  logic [CMD_W-1:0]        command,
	input  logic [CHAN_W-1:0]       channel,
	input  logic [ADDR_FIELD_W-1:0] address,
	input  logic [DATA_FIELD_W-1:0] write_data,
	input  logic                    serial_in,
	output step_ctl_t               step,
	output logic [SHIFT_W-1:0]      frame,
	output logic [CNT_W-1:0]        frame_len
);

	logic [ADDR_BITS-1:0] addr_ext;
	logic [CHAN_W-1:0]    dac_chan;

	assign addr_ext = ADDR_BITS'(address);
	// The DAC has no channel zero; it maps onto channel two.
	assign dac_chan = (channel == '0) ? 2'd2 : channel;

	always_comb begin
		step.start = 1'b0;
		step.op    = command;
		step.sin   = serial_in;
		frame      = '0;
		frame_len  = '0;
		// Frames are left-aligned so the sequencer always shifts out the top bit.
		unique case (command)
			CMD_DAC: begin
				step.start = 1'b1;
				frame[SHIFT_W-1 -: 4 + DAC_BITS] =
					{1'b1, dac_chan[0], dac_chan[1], 1'b0, write_data[DAC_BITS-1:0]};
				frame_len = CNT_W'(4 + DAC_BITS);
			end
			CMD_EWEN: begin
				step.start = 1'b1;
				frame[SHIFT_W-1 -: 3 + ADDR_BITS] = {EE_HDR_EWEN, {ADDR_BITS{1'b1}}};
				frame_len = CNT_W'(3 + ADDR_BITS);
			end
			CMD_READ: begin
				step.start = 1'b1;
				frame[SHIFT_W-1 -: 3 + ADDR_BITS] = {EE_HDR_READ, addr_ext};
				frame_len = CNT_W'(3 + ADDR_BITS);
			end
			CMD_WRITE: begin
				step.start = 1'b1;
				frame[SHIFT_W-1 -: 3 + ADDR_BITS + WORD_BITS] =
					{EE_HDR_WRITE, addr_ext, write_data[WORD_BITS-1:0]};
				frame_len = CNT_W'(3 + ADDR_BITS + WORD_BITS);
			end
			CMD_POT: begin
				step.start = 1'b1;
				frame[SHIFT_W-1 -: POT_FRAME_BITS] =
					{channel[1], channel[0], write_data[POT_CODE_BITS-1:0]};
				frame_len = CNT_W'(POT_FRAME_BITS);
			end
			default: begin
				// Clock steps and unused codes only move the current frame on.
				step.start = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/spfs_queue.sv
// Two-entry queue between the front end and the frame sequencer.
// Depends on spfs_pkg for its depth.
module spfs_queue import spfs_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/spfs_back.sv
// Frame sequencer: carries out one bus step per queued item and registers the result.
// Depends on spfs_pkg.
module spfs_back import spfs_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int DAC_BITS  = DAC_BITS_DEF,
	localparam int SHIFT_W  = frame_width(ADDR_BITS, WORD_BITS, DAC_BITS),
	localparam int CNT_W    = $clog2(SHIFT_W + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  step_ctl_t          step,
	input  logic [SHIFT_W-1:0] frame,
	input  logic [CNT_W-1:0]   frame_len,
	input  cfg_t               cfg,
	output logic               out_valid,
	input  logic               out_stall,
	output res_t               res
);

	typedef enum logic [9:0] {
		PH_IDLE   = 10'b00_0000_0001,
		PH_SHIFT  = 10'b00_0000_0010,
		PH_READ   = 10'b00_0000_0100,
		PH_DESEL  = 10'b00_0000_1000,
		PH_LOAD   = 10'b00_0001_0000,
		PH_RESEL  = 10'b00_0010_0000,
		PH_POLL   = 10'b00_0100_0000,
		PH_SETTLE = 10'b00_1000_0000,
		PH_END    = 10'b01_0000_0000,
		PH_END_TO = 10'b10_0000_0000
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [CMD_W-1:0]        op_q, op_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [SHIFT_W-1:0]      sh_q, sh_d;
	logic [WORD_BITS-1:0]    in_q, in_d;
	logic [15:0]             wait_q, wait_d;
	logic [DATA_FIELD_W-1:0] hold_q, hold_d;
	logic                    out_valid_q;
	res_t                    res_q, res_d;
	logic                    advance;

	function automatic logic [CS_W-1:0] op_select(input logic [CMD_W-1:0] op);
		if (op == CMD_DAC) return CS_DAC;
		if (op == CMD_POT) return CS_POT;
		return CS_EEPROM;
	endfunction

	// Output register frees up when its result is taken in the same cycle.
	assign advance   = q_valid && (!out_valid_q || !out_stall);
	assign q_pop     = advance;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		sh_d    = sh_q;
		in_d    = in_q;
		wait_d  = wait_q;
		hold_d  = hold_q;
		res_d   = '0;

		if (step.start && phase_q != PH_IDLE) begin
			// A start while busy leaves the frame untouched and holds its select.
			res_d.rej = 1'b1;
			unique case (phase_q)
				PH_SHIFT:                    res_d.cs = op_select(op_q);
				PH_READ, PH_RESEL, PH_POLL:  res_d.cs = CS_EEPROM;
				PH_LOAD:                     res_d.cs = CS_DAC_LOAD;
				default:                     res_d.cs = CS_NONE;
			endcase
		end else if (step.start) begin
			op_d     = step.op;
			sh_d     = frame;
			cnt_d    = frame_len;
			in_d     = '0;
			wait_d   = '0;
			phase_d  = PH_SHIFT;
			res_d.cs = op_select(step.op);
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_d = PH_IDLE;
				end
				PH_SHIFT: begin
					res_d.cs = op_select(op_q);
					if (cnt_q != '0) begin
						res_d.sout = sh_q[SHIFT_W-1];
						sh_d       = sh_q << 1;
						cnt_d      = cnt_q - 1'b1;
					end
					if (cnt_d == '0) begin
						if (op_q == CMD_DAC || op_q == CMD_WRITE) begin
							phase_d = PH_DESEL;
						end else if (op_q == CMD_READ) begin
							phase_d = PH_READ;
							cnt_d   = CNT_W'(WORD_BITS);
							in_d    = '0;
						end else if (op_q == CMD_POT) begin
							phase_d = PH_SETTLE;
							wait_d  = cfg.settle_ticks;
						end else begin
							phase_d = PH_END;
						end
					end
				end
				PH_READ: begin
					res_d.cs = CS_EEPROM;
					in_d     = {in_q[WORD_BITS-2:0], step.sin};
					if (cnt_q != '0) begin
						cnt_d = cnt_q - 1'b1;
					end
					if (cnt_d == '0) begin
						hold_d  = DATA_FIELD_W'(in_d);
						phase_d = PH_END;
					end
				end
				PH_DESEL: begin
					phase_d = (op_q == CMD_DAC) ? PH_LOAD : PH_RESEL;
				end
				PH_LOAD: begin
					res_d.cs = CS_DAC_LOAD;
					phase_d  = PH_END;
				end
				PH_RESEL: begin
					res_d.cs = CS_EEPROM;
					wait_d   = cfg.poll_limit;
					phase_d  = PH_POLL;
				end
				PH_POLL: begin
					res_d.cs = CS_EEPROM;
					if (step.sin) begin
						phase_d = PH_END;
					end else if (wait_q == '0) begin
						phase_d = PH_END_TO;
					end else begin
						wait_d = wait_q - 1'b1;
					end
				end
				PH_SETTLE: begin
					// A settle count of zero or one ends the frame on this step.
					if (wait_q <= 16'd1) begin
						res_d.done = 1'b1;
						wait_d     = '0;
						phase_d    = PH_IDLE;
					end else begin
						wait_d = wait_q - 1'b1;
					end
				end
				PH_END, PH_END_TO: begin
					res_d.done = 1'b1;
					res_d.tmo  = (phase_q == PH_END_TO);
					phase_d    = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		res_d.busy      = (phase_d != PH_IDLE);
		res_d.read_data = hold_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			op_q        <= CMD_STEP;
			cnt_q       <= '0;
			sh_q        <= '0;
			in_q        <= '0;
			wait_q      <= '0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				op_q    <= op_d;
				cnt_q   <= cnt_d;
				sh_q    <= sh_d;
				in_q    <= in_d;
				wait_q  <= wait_d;
				hold_q  <= hold_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule

### hw/rtl/serial_peripheral_frame_sequencer_core.sv
// Top level of the serial peripheral frame sequencer: configuration registers,
// front end, queue and frame sequencer. Depends on spfs_pkg, spfs_front,
// spfs_queue and spfs_back.
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------------
//   input     in_valid / in_stall    command channel address write_data serial_in
//   output    out_valid / out_stall  chip_select serial_out busy_res done_res
//                                    read_data timed_out rejected
//   config    cfg_we                 cfg_index cfg_data
//
// One item per clock sustained while the output is not stalled; each item is
// one bus step of the sequencer state machine, which updates its frame state.
// An accepted item is written into the queue, and its result is then registered
// in the output register; output stall holds it. The queue holds two items.
// Reset clears all frame state and loads the register defaults; no clearing pass.
// A stalled output holds its result while the queue keeps taking items until full.
module serial_peripheral_frame_sequencer_core import spfs_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int DAC_BITS  = DAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        command,
	input  logic [CHAN_W-1:0]       channel,
	input  logic [ADDR_FIELD_W-1:0] address,
	input  logic [DATA_FIELD_W-1:0] write_data,
	input  logic                    serial_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CS_W-1:0]         chip_select,
	output logic                    serial_out,
	output logic                    busy_res,
	output logic                    done_res,
	output logic [DATA_FIELD_W-1:0] read_data,
	output logic                    timed_out,
	output logic                    rejected,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]             cfg_data
);

	localparam int SHIFT_W = frame_width(ADDR_BITS, WORD_BITS, DAC_BITS);
	localparam int CNT_W   = $clog2(SHIFT_W + 1);
	localparam int Q_W     = $bits(step_ctl_t) + SHIFT_W + CNT_W;

	cfg_t               cfg_q;
	step_ctl_t          step_f, step_b;
	logic [SHIFT_W-1:0] frame_f, frame_b;
	logic [CNT_W-1:0]   len_f, len_b;
	logic [Q_W-1:0]     q_wdata, q_rdata;
	logic               q_full;
	logic               q_not_empty;
	logic               q_pop;
	res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_limit   <= POLL_LIMIT_RST;
			cfg_q.settle_ticks <= SETTLE_TICKS_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_POLL_LIMIT) begin
				cfg_q.poll_limit <= cfg_data;
			end else if (cfg_index == CFG_SETTLE_TICKS) begin
				cfg_q.settle_ticks <= cfg_data;
			end
		end
	end

	spfs_front #(
		.ADDR_BITS(ADDR_BITS),
		.WORD_BITS(WORD_BITS),
		.DAC_BITS (DAC_BITS)
	) u_front (
		.command   (command),
		.channel   (channel),
		.address   (address),
		.write_data(write_data),
		.serial_in (serial_in),
		.step      (step_f),
		.frame     (frame_f),
		.frame_len (len_f)
	);

	assign q_wdata  = {step_f, frame_f, len_f};
	assign in_stall = q_full;

	spfs_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.rdata    (q_rdata)
	);

	assign {step_b, frame_b, len_b} = q_rdata;

	spfs_back #(
		.ADDR_BITS(ADDR_BITS),
		.WORD_BITS(WORD_BITS),
		.DAC_BITS (DAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_not_empty),
		.q_pop    (q_pop),
		.step     (step_b),
		.frame    (frame_b),
		.frame_len(len_b),
		.cfg      (cfg_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res      (res)
	);

	assign chip_select = res.cs;
	assign serial_out  = res.sout;
	assign busy_res    = res.busy;
	assign done_res    = res.done;
	assign read_data   = res.read_data;
	assign timed_out   = res.tmo;
	assign rejected    = res.rej;

	// The sequencer only takes an item that the queue really holds.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("sequencer popped an empty queue");

	// A finishing step leaves the sequencer idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("frame reported done while still busy");

	// A rejected start neither moves the frame nor ends it.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> (busy_res && !done_res && !serial_out))
		else $error("rejected start disturbed the running frame");

	// A timeout is only flagged on the deselected finishing step of a write.
	a_timeout_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timed_out) |-> (done_res && chip_select == CS_NONE))
		else $error("timeout flagged outside a finishing step");

endmodule
